[sv/pidpi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller package
// Widths, configuration and state types, codes and the clamp function shared
// by the position/incremental PID controller.
// ----------------------------------------------------------------------------
package pidpi_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int GAIN_BITS      = 16;
	localparam int GAIN_FRAC_BITS = 8;

	localparam int ERR_BITS   = SAMPLE_BITS + 1;
	localparam int INTEG_BITS = SAMPLE_BITS + 2;
	localparam int OPD_BITS   = SAMPLE_BITS + 3;
	localparam int PROD_BITS  = GAIN_BITS + OPD_BITS;
	localparam int ACC_BITS   = GAIN_BITS + SAMPLE_BITS + 6;

	localparam int CFG_DATA_BITS = (GAIN_BITS > SAMPLE_BITS) ? GAIN_BITS : SAMPLE_BITS;
	localparam int CFG_IDX_BITS  = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MODE_INCREMENTAL = 3'd0,
		REG_GAIN_P           = 3'd1,
		REG_GAIN_I           = 3'd2,
		REG_GAIN_D           = 3'd3,
		REG_TARGET_VALUE     = 3'd4,
		REG_LIMIT_HIGH       = 3'd5,
		REG_LIMIT_LOW        = 3'd6
	} cfg_idx_t;

	localparam logic MODE_POSITION    = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		logic                          mode_incremental;
		logic signed [GAIN_BITS-1:0]   gain_p;
		logic signed [GAIN_BITS-1:0]   gain_i;
		logic signed [GAIN_BITS-1:0]   gain_d;
		logic signed [SAMPLE_BITS-1:0] target_value;
		logic signed [SAMPLE_BITS-1:0] limit_high;
		logic signed [SAMPLE_BITS-1:0] limit_low;
	} cfg_t;

	typedef struct packed {
		logic signed [INTEG_BITS-1:0]  integ;
		logic signed [ERR_BITS-1:0]    err_last;
		logic signed [ERR_BITS-1:0]    err_prev;
		logic signed [SAMPLE_BITS-1:0] held;
	} state_t;

	// The upper limit is applied first, so crossed limits give the lower one.
	function automatic logic signed [SAMPLE_BITS-1:0] clamp_acc(
		input logic signed [ACC_BITS-1:0]    v,
		input logic signed [SAMPLE_BITS-1:0] hi,
		input logic signed [SAMPLE_BITS-1:0] lo
	);
		logic signed [ACC_BITS-1:0] t;
		t = v;
		if (t > ACC_BITS'(hi)) begin
			t = ACC_BITS'(hi);
		end
		if (t < ACC_BITS'(lo)) begin
			t = ACC_BITS'(lo);
		end
		return t[SAMPLE_BITS-1:0];
	endfunction

endpackage

[sv/pidpi_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller channel interfaces
// Valid/ready channels for feedback samples and for drive results.
// ----------------------------------------------------------------------------
interface pidpi_sample_if import pidpi_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [SAMPLE_BITS-1:0] measured_value;

	modport source(output valid, output req_type, output measured_value, input ready);
	modport sink(input valid, input req_type, input measured_value, output ready);
endinterface

interface pidpi_result_if import pidpi_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] drive_value;
	logic                          at_limit;

	modport source(output valid, output drive_value, output at_limit, input ready);
	modport sink(input valid, input drive_value, input at_limit, output ready);
endinterface

[sv/pidpi_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller configuration registers
// Write-only register file for mode, gains, setpoint and output limits.
// ----------------------------------------------------------------------------
module pidpi_cfg import pidpi_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_incremental <= MODE_POSITION;
			cfg_q.gain_p           <= '0;
			cfg_q.gain_i           <= '0;
			cfg_q.gain_d           <= '0;
			cfg_q.target_value     <= '0;
			cfg_q.limit_high       <= SAMPLE_MAX;
			cfg_q.limit_low        <= SAMPLE_MIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE_INCREMENTAL: cfg_q.mode_incremental <= cfg_wdata[0];
				REG_GAIN_P:           cfg_q.gain_p       <= cfg_wdata[GAIN_BITS-1:0];
				REG_GAIN_I:           cfg_q.gain_i       <= cfg_wdata[GAIN_BITS-1:0];
				REG_GAIN_D:           cfg_q.gain_d       <= cfg_wdata[GAIN_BITS-1:0];
				REG_TARGET_VALUE:     cfg_q.target_value <= cfg_wdata[SAMPLE_BITS-1:0];
				REG_LIMIT_HIGH:       cfg_q.limit_high   <= cfg_wdata[SAMPLE_BITS-1:0];
				REG_LIMIT_LOW:        cfg_q.limit_low    <= cfg_wdata[SAMPLE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/pidpi_calc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller update logic
// One control step: error, integral clamp, three shared gain multipliers,
// scaling, output clamp and the next controller state (all zero on a clear).
// ----------------------------------------------------------------------------
module pidpi_calc import pidpi_pkg::*; (
	input  cfg_t                          cfg,
	input  logic                          req_type,
	input  logic signed [SAMPLE_BITS-1:0] measured_value,
	input  state_t                        state,
	output state_t                        state_d,
	output logic signed [SAMPLE_BITS-1:0] drive_value,
	output logic                          at_limit
);

	logic                          is_inc;
	logic signed [ERR_BITS-1:0]    err;
	logic signed [OPD_BITS-1:0]    err_w;
	logic signed [OPD_BITS-1:0]    el_w;
	logic signed [OPD_BITS-1:0]    eb_w;
	logic signed [OPD_BITS-1:0]    diff1;
	logic signed [OPD_BITS-1:0]    diff2;
	logic signed [ACC_BITS-1:0]    integ_acc;
	logic signed [SAMPLE_BITS-1:0] integ_cl;
	logic signed [INTEG_BITS-1:0]  integ_back;
	logic signed [OPD_BITS-1:0]    opd_p;
	logic signed [OPD_BITS-1:0]    opd_i;
	logic signed [OPD_BITS-1:0]    opd_d;
	logic signed [PROD_BITS-1:0]   prod_p;
	logic signed [PROD_BITS-1:0]   prod_i;
	logic signed [PROD_BITS-1:0]   prod_d;
	logic signed [ACC_BITS-1:0]    sum;
	logic signed [ACC_BITS-1:0]    scaled;
	logic signed [ACC_BITS-1:0]    base;
	logic signed [ACC_BITS-1:0]    total;
	logic signed [SAMPLE_BITS-1:0] res;
	logic                          lim;

	assign is_inc = (cfg.mode_incremental == MODE_INCREMENTAL);

	assign err   = ERR_BITS'(cfg.target_value) - ERR_BITS'(measured_value);
	assign err_w = OPD_BITS'(err);
	assign el_w  = OPD_BITS'(state.err_last);
	assign eb_w  = OPD_BITS'(state.err_prev);
	assign diff1 = err_w - el_w;
	assign diff2 = err_w - (el_w <<< 1) + eb_w;

	assign integ_acc  = ACC_BITS'(state.integ) + ACC_BITS'(err);
	assign integ_cl   = clamp_acc(integ_acc, cfg.limit_high, cfg.limit_low);
	assign integ_back = INTEG_BITS'(integ_cl) - INTEG_BITS'(err);

	assign opd_p = is_inc ? diff1 : err_w;
	assign opd_i = is_inc ? err_w : OPD_BITS'(integ_cl);
	assign opd_d = is_inc ? diff2 : diff1;

	assign prod_p = cfg.gain_p * opd_p;
	assign prod_i = cfg.gain_i * opd_i;
	assign prod_d = cfg.gain_d * opd_d;

	assign sum    = ACC_BITS'(prod_p) + ACC_BITS'(prod_i) + ACC_BITS'(prod_d);
	assign scaled = sum >>> GAIN_FRAC_BITS;
	assign base   = is_inc ? ACC_BITS'(state.held) : '0;
	assign total  = scaled + base;
	assign res    = clamp_acc(total, cfg.limit_high, cfg.limit_low);
	assign lim    = (res >= cfg.limit_high) || (res <= cfg.limit_low);

	always_comb begin
		if (req_type == REQ_CLEAR) begin
			state_d     = '0;
			drive_value = '0;
			at_limit    = 1'b0;
		end else begin
			state_d.err_last = err;
			state_d.held     = res;
			if (is_inc) begin
				state_d.integ    = state.integ;
				state_d.err_prev = state.err_last;
			end else begin
				state_d.integ    = lim ? integ_back : INTEG_BITS'(integ_cl);
				state_d.err_prev = state.err_prev;
			end
			drive_value = res;
			at_limit    = lim;
		end
	end

endmodule

[sv/pid_position_incremental_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller, position and incremental forms
// Turns each feedback sample into a clamped drive value in signed fixed point.
//
//   Port      Direction  Beat contents
//   sample    in         req_type, measured_value
//   result    out        drive_value, at_limit
//   cfg_*     in         register write (index 0..6), no read-back
//
// A sample is registered, the step is computed in the following cycle and the
// result lands in the output register; one beat per cycle is sustained while
// the result side holds ready high. The rate is set by the state update loop.
// A stalled output register holds back the input register only, and a new
// sample is still taken when the stage ahead moves on in the same cycle.
// Reset clears the history and loads the default registers at once.
// ----------------------------------------------------------------------------
module pid_position_incremental_core import pidpi_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	pidpi_sample_if.sink             sample,
	pidpi_result_if.source           result
);

	cfg_t                          cfg;
	state_t                        state_q;
	state_t                        state_d;
	logic                          valid_s1;
	logic                          req_s1;
	logic signed [SAMPLE_BITS-1:0] meas_s1;
	logic                          res_valid_q;
	logic signed [SAMPLE_BITS-1:0] drive_q;
	logic                          at_limit_q;
	logic signed [SAMPLE_BITS-1:0] drive_d;
	logic                          at_limit_d;
	logic                          advance;

	pidpi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pidpi_calc u_calc (
		.cfg            (cfg),
		.req_type       (req_s1),
		.measured_value (meas_s1),
		.state          (state_q),
		.state_d        (state_d),
		.drive_value    (drive_d),
		.at_limit       (at_limit_d)
	);

	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			req_s1  <= sample.req_type;
			meas_s1 <= sample.measured_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			state_q     <= '0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
			state_q     <= state_d;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q    <= drive_d;
			at_limit_q <= at_limit_d;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.drive_value = drive_q;
	assign result.at_limit    = at_limit_q;

endmodule

[sv/pidpi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller port checker
// Watches the channels of the controller core and flags flow slips.
// ----------------------------------------------------------------------------
module pidpi_checker import pidpi_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_valid,
	input logic                          s_ready,
	input logic                          r_valid,
	input logic                          r_ready,
	input logic signed [SAMPLE_BITS-1:0] r_drive,
	input logic                          r_at_limit
);

	// A stalled result beat must hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_drive) && $stable(r_at_limit))
		else $error("result beat changed while stalled");

	// A beat taken while the output register is free goes on to the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(s_valid && s_ready) && !r_valid |=> r_valid)
		else $error("accepted sample did not reach the output");

	// With a beat in flight and the output stalled, no further sample is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(s_valid && s_ready) && r_valid && !r_ready |-> !s_ready)
		else $error("sample taken while both stages are full");

	// No result straight out of reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !r_valid)
		else $error("result presented without an accepted sample");

endmodule

bind pid_position_incremental_core pidpi_checker u_pidpi_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.s_valid    (sample.valid),
	.s_ready    (sample.ready),
	.r_valid    (result.valid),
	.r_ready    (result.ready),
	.r_drive    (result.drive_value),
	.r_at_limit (result.at_limit)
);
